@@ rtl/nas_pkg.sv @@
// nas_pkg: shared types and constants of the nice axis scale block
// no dependencies; imported by every module of the block
`default_nettype none

package nas_pkg;

    // field widths
    localparam int DATA_W = 64;
    localparam int WANT_W = 63;
    localparam int WIDE_W = 68;
    localparam int CNT_W  = 6;

    // zero maximum special case and the saturated top
    localparam logic [DATA_W-1:0] ZERO_STEP = 64'd100;
    localparam logic [DATA_W-1:0] ZERO_TOP  = 64'd400;
    localparam logic [DATA_W-1:0] ALL_ONES  = {DATA_W{1'b1}};

    // leading multiplier codes walked during the lead search
    typedef logic [1:0] mult_t;
    localparam mult_t MULT_ONE  = 2'd0;
    localparam mult_t MULT_TWO  = 2'd1;
    localparam mult_t MULT_FIVE = 2'd2;
    localparam mult_t MULT_TEN  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECADE,
        S_LEAD,
        S_DIV,
        S_OUT
    } state_t;

endpackage

`default_nettype wire

@@ rtl/nas_rem_unit.sv @@
// nas_rem_unit: bit-serial restoring remainder, one dividend bit per cycle
// depends on nas_pkg
`default_nettype none

module nas_rem_unit
    import nas_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [DATA_W-1:0] dividend,
    input  wire logic [DATA_W-1:0] divisor,
    output logic                   done,
    output logic      [DATA_W-1:0] rem
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W:0]   trial;

    // divisor is held steady by the caller for the whole run
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        trial     = {rem_reg, dvd_reg[DATA_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor})
                rem_next = DATA_W'(trial - {1'b0, divisor});
            else
                rem_next = trial[DATA_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == {CNT_W{1'b1}})
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

@@ rtl/nice_axis_scale_unit.sv @@
// nice_axis_scale_unit: picks a 1-2-5 tick step and an axis top for a data maximum
// depends on nas_pkg and nas_rem_unit
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------
//   in      | input     | in_valid/in_stall   | data_maximum
//   out     | output    | out_valid/out_stall | axis_top, tick_size
//
// one transaction at a time; the time from accept to result is set by the
// decade search (one times ten per cycle), the lead search (1 to 4 compares),
// the bit-serial remainder (load, 64 bits, done) and the output state
// results sit in an output register, so a new transaction is taken while the
// previous result is still stalled; the block waits in the last state only if
// that register is still full when the next result is ready
// reset clears the state machine and the output valid flag
`default_nettype none

module nice_axis_scale_unit
    import nas_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [DATA_W-1:0] data_maximum,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic      [DATA_W-1:0] axis_top,
    output logic      [DATA_W-1:0] tick_size
);

    state_t            state_reg, state_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic [WANT_W-1:0] want_reg, want_next;
    logic [DATA_W-1:0] dec_reg, dec_next;
    mult_t             phase_reg, phase_next;
    logic [DATA_W-1:0] step_reg, step_next;
    logic              zero_reg, zero_next;
    logic              nz_reg, nz_next;
    logic              start_reg, start_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] tick_reg, tick_next;

    logic [WIDE_W-1:0] ten;
    logic [WIDE_W-1:0] cand;
    logic [WIDE_W-1:0] dec_w;
    logic [DATA_W:0]   sum;
    logic              div_done;
    logic [DATA_W-1:0] div_rem;

    // remainder of the maximum by the chosen step
    nas_rem_unit u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .dividend (data_reg),
        .divisor  (step_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // decade times ten, and the candidate step of the current lead digit
    assign dec_w = WIDE_W'(dec_reg);
    assign ten   = (dec_w << 3) + (dec_w << 1);

    always_comb
    begin
        case (phase_reg)
            MULT_ONE:  cand = dec_w;
            MULT_TWO:  cand = dec_w << 1;
            MULT_FIVE: cand = (dec_w << 2) + dec_w;
            default:   cand = (dec_w << 3) + (dec_w << 1);
        endcase
    end

    // rounded-up top is the maximum minus remainder plus one step
    assign sum = {1'b0, data_reg} + {1'b0, step_reg};

    always_comb
    begin
        state_next     = state_reg;
        data_next      = data_reg;
        want_next      = want_reg;
        dec_next       = dec_reg;
        phase_next     = phase_reg;
        step_next      = step_reg;
        zero_next      = zero_reg;
        nz_next        = nz_reg;
        start_next     = 1'b0;
        out_valid_next = out_valid_reg;
        top_next       = top_reg;
        tick_next      = tick_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    data_next = data_maximum;
                    zero_next = (data_maximum == '0);
                    // ceiling of maximum over four, 100 for a zero maximum
                    if (data_maximum == '0)
                        want_next = WANT_W'(ZERO_STEP);
                    else
                        want_next = WANT_W'(data_maximum[DATA_W-1:2])
                                  + WANT_W'(|data_maximum[1:0]);
                    dec_next   = DATA_W'(1);
                    state_next = S_DECADE;
                end
            end
            S_DECADE:
            begin
                // largest power of ten not above the request
                if (ten <= WIDE_W'(want_reg))
                    dec_next = ten[DATA_W-1:0];
                else
                begin
                    phase_next = MULT_ONE;
                    state_next = S_LEAD;
                end
            end
            S_LEAD:
            begin
                if (cand >= WIDE_W'(want_reg) || phase_reg == MULT_TEN)
                begin
                    step_next  = cand[DATA_W-1:0];
                    start_next = 1'b1;
                    state_next = S_DIV;
                end
                else
                    phase_next = phase_reg + 2'd1;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    data_next  = data_reg - div_rem;
                    nz_next    = (div_rem != '0);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    tick_next      = step_reg;
                    if (zero_reg)
                        top_next = ZERO_TOP;
                    else if (!nz_reg)
                        top_next = data_reg;
                    else if (sum[DATA_W])
                        top_next = ALL_ONES;
                    else
                        top_next = sum[DATA_W-1:0];
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        want_reg  <= want_next;
        dec_reg   <= dec_next;
        phase_reg <= phase_next;
        step_reg  <= step_next;
        zero_reg  <= zero_next;
        nz_reg    <= nz_next;
        top_reg   <= top_next;
        tick_reg  <= tick_next;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign axis_top  = top_reg;
    assign tick_size = tick_reg;

endmodule

`default_nettype wire

@@ rtl/nas_checker.sv @@
// nas_checker: port-level checks of the nice axis scale block
// depends on nas_pkg; bound to nice_axis_scale_unit below
`default_nettype none

module nas_checker
    import nas_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic [DATA_W-1:0] data_maximum,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [DATA_W-1:0] axis_top,
    input wire logic [DATA_W-1:0] tick_size
);

    // a stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(data_maximum))
        else $error("stalled input changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(axis_top) && $stable(tick_size))
        else $error("stalled result changed");

    // an accepted transaction keeps the input side busy next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken twice in a row");

    a_step_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> tick_size != '0)
        else $error("zero tick step");

    a_top_covers_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> axis_top >= tick_size)
        else $error("axis top below tick step");

endmodule

bind nice_axis_scale_unit nas_checker u_nas_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_maximum (data_maximum),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .axis_top     (axis_top),
    .tick_size    (tick_size)
);

`default_nettype wire
